// ===== rtl/apc_pkg.sv =====
package apc_pkg;

  // Configuration register widths (fixed by the register map).
  localparam int GainW   = 8;
  localparam int OffsetW = 12;
  localparam int StepW   = 8;
  localparam int LimitW  = 7;
  localparam int DriveW  = 8;

  // APB register map: register index sits at paddr[AddrW-1:2].
  localparam int AddrW   = 5;
  localparam int RegIdxW = 3;

  typedef enum logic [RegIdxW-1:0] {
    REG_GAIN        = 3'd0,
    REG_MID_OFFSET  = 3'd1,
    REG_HIGH_OFFSET = 3'd2,
    REG_NUDGE_STEP  = 3'd3,
    REG_DRIVE_LIMIT = 3'd4
  } reg_idx_e;

  localparam logic [GainW-1:0]   GainRst       = 8'd77;
  localparam logic [OffsetW-1:0] MidOffsetRst  = 12'd800;
  localparam logic [OffsetW-1:0] HighOffsetRst = 12'd1500;
  localparam logic [StepW-1:0]   NudgeStepRst  = 8'd25;
  localparam logic [LimitW-1:0]  DriveLimitRst = 7'd127;

  // Preset reset values on a 12-bit ADC scale; scaled for other ADC widths.
  localparam int PresetLowRst12  = 3800;
  localparam int PresetMidRst12  = 3000;
  localparam int PresetHighRst12 = 2300;

  typedef struct packed {
    logic [GainW-1:0]   gain_q8;
    logic [OffsetW-1:0] mid_offset;
    logic [OffsetW-1:0] high_offset;
    logic [StepW-1:0]   nudge_step;
    logic [LimitW-1:0]  drive_limit;
  } apc_cfg_t;

  typedef struct packed {
    logic preset_high_btn;
    logic preset_mid_btn;
    logic preset_low_btn;
    logic nudge_up_btn;
    logic nudge_down_btn;
    logic limit_left;
    logic limit_right;
  } apc_btn_t;

endpackage

// ===== rtl/apc_cfg_regs.sv =====
module apc_cfg_regs
  import apc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output apc_cfg_t         cfg_o
);

  apc_cfg_t cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_q8     <= GainRst;
      cfg_q.mid_offset  <= MidOffsetRst;
      cfg_q.high_offset <= HighOffsetRst;
      cfg_q.nudge_step  <= NudgeStepRst;
      cfg_q.drive_limit <= DriveLimitRst;
    end else if (wr_en) begin
      unique case (idx)
        REG_GAIN:        cfg_q.gain_q8     <= pwdata[GainW-1:0];
        REG_MID_OFFSET:  cfg_q.mid_offset  <= pwdata[OffsetW-1:0];
        REG_HIGH_OFFSET: cfg_q.high_offset <= pwdata[OffsetW-1:0];
        REG_NUDGE_STEP:  cfg_q.nudge_step  <= pwdata[StepW-1:0];
        REG_DRIVE_LIMIT: cfg_q.drive_limit <= pwdata[LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN:        prdata = {{(32-GainW){1'b0}}, cfg_q.gain_q8};
      REG_MID_OFFSET:  prdata = {{(32-OffsetW){1'b0}}, cfg_q.mid_offset};
      REG_HIGH_OFFSET: prdata = {{(32-OffsetW){1'b0}}, cfg_q.high_offset};
      REG_NUDGE_STEP:  prdata = {{(32-StepW){1'b0}}, cfg_q.nudge_step};
      REG_DRIVE_LIMIT: prdata = {{(32-LimitW){1'b0}}, cfg_q.drive_limit};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/apc_core.sv =====
module apc_core
  import apc_pkg::*;
#(
  parameter int ADC_WIDTH = 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  apc_cfg_t                 cfg_i,
  input  logic [ADC_WIDTH-1:0]     pot_right_i,
  input  logic [ADC_WIDTH-1:0]     pot_left_i,
  input  apc_btn_t                 btn_i,
  output logic signed [DriveW-1:0] drive_o,
  output logic [ADC_WIDTH-1:0]     setpoint_o
);

  localparam int W    = ADC_WIDTH;
  localparam int CmpW = (W > OffsetW) ? W : OffsetW;
  localparam logic [W-1:0] AdcMax = {W{1'b1}};
  localparam logic [W-1:0] LowRst  = W'(PresetLowRst12 * (1 << W) / 4096);
  localparam logic [W-1:0] MidRst  = W'(PresetMidRst12 * (1 << W) / 4096);
  localparam logic [W-1:0] HighRst = W'(PresetHighRst12 * (1 << W) / 4096);

  logic [W-1:0]    setpoint_q, setpoint_d;
  logic [W-1:0]    low_q, low_d, mid_q, mid_d, high_q, high_d;
  logic [W:0]      pot_sum;
  logic [W-1:0]    avg;
  logic [W-1:0]    step_ext;
  logic [W:0]      up_sum;
  logic [CmpW-1:0] avg_c, mid_off_c, high_off_c;
  logic            lim_closed;
  logic            neg;
  logic [W-1:0]    err_mag;
  logic [W+GainW-1:0] product;
  logic [W-1:0]    scaled;
  logic [LimitW-1:0] mag;

  assign pot_sum    = {1'b0, pot_right_i} + {1'b0, pot_left_i};
  assign avg        = pot_sum[W:1];
  assign step_ext   = W'(cfg_i.nudge_step);
  assign up_sum     = {1'b0, setpoint_q} + {1'b0, step_ext};
  assign avg_c      = CmpW'(avg);
  assign mid_off_c  = CmpW'(cfg_i.mid_offset);
  assign high_off_c = CmpW'(cfg_i.high_offset);
  // A switch pin reads 0 when the switch is closed.
  assign lim_closed = !btn_i.limit_left || !btn_i.limit_right;

  always_comb begin
    setpoint_d = setpoint_q;
    low_d      = low_q;
    mid_d      = mid_q;
    high_d     = high_q;
    if (btn_i.preset_high_btn) begin
      setpoint_d = high_q;
    end else if (btn_i.preset_mid_btn) begin
      setpoint_d = mid_q;
    end else if (btn_i.preset_low_btn) begin
      setpoint_d = low_q;
    end else if (btn_i.nudge_up_btn) begin
      setpoint_d = (setpoint_q > step_ext) ? setpoint_q - step_ext : '0;
    end else if (btn_i.nudge_down_btn) begin
      setpoint_d = (up_sum > {1'b0, AdcMax}) ? AdcMax : up_sum[W-1:0];
    end else if (lim_closed) begin
      setpoint_d = avg;
      low_d      = avg;
      mid_d      = (avg_c > mid_off_c) ? W'(avg_c - mid_off_c) : '0;
      high_d     = (avg_c > high_off_c) ? W'(avg_c - high_off_c) : '0;
    end
  end

  // Proportional term on the updated setpoint, sign-magnitude form.
  always_comb begin
    neg     = setpoint_d < avg;
    err_mag = neg ? avg - setpoint_d : setpoint_d - avg;
    product = (W+GainW)'(err_mag) * (W+GainW)'(cfg_i.gain_q8);
    scaled  = product[W+GainW-1:GainW];
    mag     = (scaled > W'(cfg_i.drive_limit)) ? cfg_i.drive_limit : scaled[LimitW-1:0];
    drive_o = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  assign setpoint_o = setpoint_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= '0;
      low_q      <= LowRst;
      mid_q      <= MidRst;
      high_q     <= HighRst;
    end else if (step_i) begin
      setpoint_q <= setpoint_d;
      low_q      <= low_d;
      mid_q      <= mid_d;
      high_q     <= high_d;
    end
  end

endmodule

// ===== rtl/arm_position_p_controller_unit.sv =====
// Channel     | Direction | Transfer contents
// s_axis      | in        | tdata: pot_right, pot_left, preset_high_btn, preset_mid_btn,
//             |           |        preset_low_btn, nudge_up_btn, nudge_down_btn,
//             |           |        limit_left, limit_right
// m_axis      | out       | tdata: drive, setpoint_now
// APB         | in        | gain_q8, mid_offset, high_offset, nudge_step, drive_limit
//
// One item per cycle sustained while m_axis_tready stays high; an item passes the input register
// and then the result register around the single-pass datapath.
// The setpoint and presets update when an item moves from the input register into the
// result register, so a stalled output holds the state as well.
// Reset is asynchronous and active low; it loads the register and preset defaults.
module arm_position_p_controller_unit
  import apc_pkg::*;
#(
  parameter int ADC_WIDTH = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // APB configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Input stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // From bit 0: pot_right, pot_left, preset_high_btn, preset_mid_btn, preset_low_btn,
  // nudge_up_btn, nudge_down_btn, limit_left, limit_right, zero fill
  input  logic [((2*ADC_WIDTH+7+7)/8)*8-1:0] s_axis_tdata,
  // Output stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // From bit 0: drive, setpoint_now, zero fill
  output logic [((DriveW+ADC_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

  localparam int W      = ADC_WIDTH;
  localparam int OutW   = ((DriveW+W+7)/8)*8;

  apc_cfg_t cfg;

  logic                     in_valid_q;
  logic [W-1:0]             pot_right_q, pot_left_q;
  apc_btn_t                 btn_q;
  logic                     out_valid_q;
  logic signed [DriveW-1:0] drive_q;
  logic [W-1:0]             setpoint_q;

  logic                     out_load;
  logic                     in_load;
  logic signed [DriveW-1:0] drive_d;
  logic [W-1:0]             setpoint_d;
  apc_btn_t                 btn_in;

  apc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  apc_core #(
    .ADC_WIDTH (ADC_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (out_load),
    .cfg_i       (cfg),
    .pot_right_i (pot_right_q),
    .pot_left_i  (pot_left_q),
    .btn_i       (btn_q),
    .drive_o     (drive_d),
    .setpoint_o  (setpoint_d)
  );

  // The button fields sit above the two pot samples, highest priority first.
  assign btn_in = apc_btn_t'({s_axis_tdata[2*W], s_axis_tdata[2*W+1], s_axis_tdata[2*W+2],
                              s_axis_tdata[2*W+3], s_axis_tdata[2*W+4],
                              s_axis_tdata[2*W+5], s_axis_tdata[2*W+6]});

  assign out_load      = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || out_load;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_load) begin
        in_valid_q <= 1'b1;
      end else if (out_load) begin
        in_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      pot_right_q <= s_axis_tdata[W-1:0];
      pot_left_q  <= s_axis_tdata[2*W-1:W];
      btn_q       <= btn_in;
    end
    if (out_load) begin
      drive_q    <= drive_d;
      setpoint_q <= setpoint_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutW-DriveW-W){1'b0}}, setpoint_q, drive_q};

  // The full clamp range is symmetric, so the most negative code never appears.
  a_drive_symmetric : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[DriveW-1:0] != {1'b1, {(DriveW-1){1'b0}}}))
    else $error("drive holds the most negative code");

  // An empty result register never stalls the input side.
  a_no_false_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // An accepted item always reaches the input register.
  a_in_captured : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> in_valid_q)
    else $error("accepted transfer was dropped");

  // A pending item moves on as soon as the result register frees up.
  a_pipe_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && m_axis_tready) |=> m_axis_tvalid)
    else $error("result missing after input register drained");

endmodule

// ===== bench/tb_arm_position_p_controller_unit.sv =====
module tb_arm_position_p_controller_unit;
  import apc_pkg::*;

  localparam int AdcW   = 12;
  localparam int AdcMax = (1 << AdcW) - 1;

  // Button select encoding used by the directed table: high, mid, low, up, down.
  localparam logic [4:0] BtnNone = 5'b00000;
  localparam logic [4:0] BtnHigh = 5'b10000;
  localparam logic [4:0] BtnMid  = 5'b01000;
  localparam logic [4:0] BtnLow  = 5'b00100;
  localparam logic [4:0] BtnUp   = 5'b00010;
  localparam logic [4:0] BtnDown = 5'b00001;
  localparam logic [4:0] BtnAll  = 5'b11111;

  // Limit switch pins {left, right}; a pin at 0 means the switch is closed.
  localparam logic [1:0] LimOpen        = 2'b11;
  localparam logic [1:0] LimLeftClosed  = 2'b01;
  localparam logic [1:0] LimRightClosed = 2'b10;
  localparam logic [1:0] LimBothClosed  = 2'b00;

  localparam logic [RegIdxW-1:0] FirstUnusedIdx = RegIdxW'(REG_DRIVE_LIMIT) + 1'b1;

  // Packed so that the last field lands in the lowest bits of tdata.
  typedef struct packed {
    logic            limit_right;
    logic            limit_left;
    logic            nudge_down_btn;
    logic            nudge_up_btn;
    logic            preset_low_btn;
    logic            preset_mid_btn;
    logic            preset_high_btn;
    logic [AdcW-1:0] pot_left;
    logic [AdcW-1:0] pot_right;
  } ctl_tick_t;

  typedef struct packed {
    logic [AdcW-1:0]          setpoint_now;
    logic signed [DriveW-1:0] drive;
  } ctl_result_t;

  typedef struct packed {
    logic [AdcW-1:0]          pot_right;
    logic [AdcW-1:0]          pot_left;
    logic [4:0]               btn;
    logic [1:0]               pins;
    logic                     typed;
    logic signed [DriveW-1:0] drive;
    logic [AdcW-1:0]          setpoint;
  } directed_row_t;

  // Rows run under the reset configuration; typed rows carry a result read off by hand.
  localparam directed_row_t DirectedRows [16] = '{
    '{12'd0,    12'd0,    BtnNone,                        LimOpen,        1'b1, 8'sd0,    12'd0},
    '{12'd0,    12'd0,    BtnHigh,                        LimOpen,        1'b1, 8'sd127,  12'd2300},
    '{12'd4095, 12'd4095, BtnMid | BtnLow | BtnUp | BtnDown, LimOpen,     1'b1, -8'sd127, 12'd3000},
    '{12'd3800, 12'd3800, BtnLow,                         LimOpen,        1'b1, 8'sd0,    12'd3800},
    '{12'd4095, 12'd0,    BtnAll,                         LimBothClosed,  1'b0, 8'sd0,    12'd0},
    '{12'd2300, 12'd2200, BtnUp,                          LimOpen,        1'b0, 8'sd0,    12'd0},
    '{12'd1000, 12'd1100, BtnDown,                        LimBothClosed,  1'b0, 8'sd0,    12'd0},
    '{12'd10,   12'd10,   BtnNone,                        LimLeftClosed,  1'b1, 8'sd0,    12'd10},
    '{12'd0,    12'd0,    BtnUp,                          LimOpen,        1'b1, 8'sd0,    12'd0},
    '{12'd4095, 12'd4095, BtnHigh,                        LimOpen,        1'b1, -8'sd127, 12'd0},
    '{12'd4095, 12'd4095, BtnMid,                         LimOpen,        1'b1, -8'sd127, 12'd0},
    '{12'd4095, 12'd4095, BtnNone,                        LimRightClosed, 1'b1, 8'sd0,    12'd4095},
    '{12'd4095, 12'd4095, BtnDown,                        LimOpen,        1'b1, 8'sd0,    12'd4095},
    '{12'd0,    12'd4095, BtnMid,                         LimOpen,        1'b0, 8'sd0,    12'd0},
    '{12'd2000, 12'd2001, BtnLow,                         LimOpen,        1'b0, 8'sd0,    12'd0},
    '{12'd3290, 12'd3300, BtnUp,                          LimOpen,        1'b0, 8'sd0,    12'd0}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [AddrW-1:0] paddr    = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // From bit 0: pot_right, pot_left, preset_high_btn, preset_mid_btn, preset_low_btn,
  // nudge_up_btn, nudge_down_btn, limit_left, limit_right, zero fill
  logic [31:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // From bit 0: drive, setpoint_now, zero fill
  logic [23:0] m_axis_tdata;

  arm_position_p_controller_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  apc_cfg_t        exp_cfg;
  logic [AdcW-1:0] exp_setpoint;
  logic [AdcW-1:0] exp_preset_low;
  logic [AdcW-1:0] exp_preset_mid;
  logic [AdcW-1:0] exp_preset_high;

  ctl_result_t pending_results [$];
  int          fail_count = 0;
  bit          steady_run = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(string what, int got, int want);
    fail_count++;
    if (fail_count <= 40) begin
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    end
  endtask

  function automatic logic [AdcW-1:0] floor_sub(logic [AdcW-1:0] a, logic [AdcW-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  // One control tick: setpoint update by priority, then the clamped proportional drive.
  function automatic ctl_result_t advance_controller(ctl_tick_t t);
    logic [AdcW:0]     pot_sum;
    logic [AdcW-1:0]   avg;
    logic [AdcW:0]     raised;
    logic [AdcW-1:0]   err_mag;
    logic [19:0]       product;
    logic [AdcW-1:0]   mag;
    logic              neg;
    ctl_result_t       r;
    pot_sum = {1'b0, t.pot_right} + {1'b0, t.pot_left};
    avg     = pot_sum[AdcW:1];
    if (t.preset_high_btn) begin
      exp_setpoint = exp_preset_high;
    end else if (t.preset_mid_btn) begin
      exp_setpoint = exp_preset_mid;
    end else if (t.preset_low_btn) begin
      exp_setpoint = exp_preset_low;
    end else if (t.nudge_up_btn) begin
      exp_setpoint = floor_sub(exp_setpoint, AdcW'(exp_cfg.nudge_step));
    end else if (t.nudge_down_btn) begin
      raised       = {1'b0, exp_setpoint} + (AdcW+1)'(exp_cfg.nudge_step);
      exp_setpoint = (raised > AdcMax) ? AdcW'(AdcMax) : raised[AdcW-1:0];
    end else if (!t.limit_left || !t.limit_right) begin
      exp_setpoint    = avg;
      exp_preset_low  = avg;
      exp_preset_mid  = floor_sub(avg, exp_cfg.mid_offset);
      exp_preset_high = floor_sub(avg, exp_cfg.high_offset);
    end
    neg     = exp_setpoint < avg;
    err_mag = neg ? avg - exp_setpoint : exp_setpoint - avg;
    product = 20'(exp_cfg.gain_q8) * 20'(err_mag);
    mag     = product[19:8];
    if (mag > exp_cfg.drive_limit) begin
      mag = AdcW'(exp_cfg.drive_limit);
    end
    r.setpoint_now = exp_setpoint;
    r.drive        = neg ? -$signed(mag[DriveW-1:0]) : $signed(mag[DriveW-1:0]);
    return r;
  endfunction

  function automatic void apply_reg_write(logic [RegIdxW-1:0] idx, logic [31:0] data);
    case (idx)
      REG_GAIN:        exp_cfg.gain_q8     = data[GainW-1:0];
      REG_MID_OFFSET:  exp_cfg.mid_offset  = data[OffsetW-1:0];
      REG_HIGH_OFFSET: exp_cfg.high_offset = data[OffsetW-1:0];
      REG_NUDGE_STEP:  exp_cfg.nudge_step  = data[StepW-1:0];
      REG_DRIVE_LIMIT: exp_cfg.drive_limit = data[LimitW-1:0];
      default: ;
    endcase
  endfunction

  // Bits above the register width are junk; the block must drop them.
  function automatic logic [31:0] with_upper_noise(int unsigned value, int width);
    logic [31:0] junk;
    junk = $urandom();
    return (junk << width) | value;
  endfunction

  function automatic ctl_tick_t tick_of(int pr, int pl, logic [4:0] btn, logic [1:0] pins);
    ctl_tick_t t;
    t.pot_right       = AdcW'(pr);
    t.pot_left        = AdcW'(pl);
    t.preset_high_btn = btn[4];
    t.preset_mid_btn  = btn[3];
    t.preset_low_btn  = btn[2];
    t.nudge_up_btn    = btn[1];
    t.nudge_down_btn  = btn[0];
    t.limit_left      = pins[1];
    t.limit_right     = pins[0];
    return t;
  endfunction

  // Mostly single buttons or none, so nudges and recalibration get exercised;
  // pots often sit near the setpoint so the drive stays below its clamp.
  function automatic ctl_tick_t random_tick();
    int         pr;
    int         pl;
    logic [4:0] btn;
    logic [1:0] pins;
    case ($urandom_range(0, 9))
      0:       btn = BtnHigh;
      1:       btn = BtnMid;
      2:       btn = BtnLow;
      3, 4:    btn = BtnUp;
      5, 6:    btn = BtnDown;
      default: btn = BtnNone;
    endcase
    if ($urandom_range(0, 3) == 0) begin
      btn = btn | 5'($urandom());
    end
    pins[1] = ($urandom_range(0, 5) != 0);
    pins[0] = ($urandom_range(0, 5) != 0);
    case ($urandom_range(0, 3))
      0: begin
        pr = int'(exp_setpoint) + int'($urandom_range(0, 600)) - 300;
        pr = (pr < 0) ? 0 : (pr > AdcMax) ? AdcMax : pr;
        pl = pr + int'($urandom_range(0, 2)) - 1;
        pl = (pl < 0) ? 0 : (pl > AdcMax) ? AdcMax : pl;
      end
      1: begin
        pr = $urandom_range(0, 1) * AdcMax;
        pl = $urandom_range(0, 1) * AdcMax;
      end
      default: begin
        pr = $urandom_range(0, AdcMax);
        pl = $urandom_range(0, AdcMax);
      end
    endcase
    return tick_of(pr, pl, btn, pins);
  endfunction

  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    apply_reg_write(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_tick(ctl_tick_t t, logic typed, ctl_result_t typed_want);
    ctl_result_t predicted;
    if (!steady_run && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, t};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = advance_controller(t);
    pending_results.push_back(typed ? typed_want : predicted);
  endtask

  task automatic wait_for_results();
    int guard;
    guard = 0;
    while (pending_results.size() != 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Result side: random stalls in bursts, none once the steady tail begins.
  initial begin
    @(posedge rst_ni);
    forever begin
      if (!steady_run && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    ctl_result_t got;
    ctl_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = ctl_result_t'(m_axis_tdata[19:0]);
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with nothing pending", int'(got.drive), 0);
      end else begin
        want = pending_results.pop_front();
        if (got.drive !== want.drive) begin
          report_mismatch("drive", int'(got.drive), int'(want.drive));
        end
        if (got.setpoint_now !== want.setpoint_now) begin
          report_mismatch("setpoint_now", int'(got.setpoint_now), int'(want.setpoint_now));
        end
      end
    end
  end

  initial begin
    directed_row_t row;
    int unsigned   gain;
    int unsigned   mid_off;
    int unsigned   high_off;
    int unsigned   step;
    int unsigned   lim;
    exp_cfg         = '{GainRst, MidOffsetRst, HighOffsetRst, NudgeStepRst, DriveLimitRst};
    exp_setpoint    = '0;
    exp_preset_low  = AdcW'(PresetLowRst12);
    exp_preset_mid  = AdcW'(PresetMidRst12);
    exp_preset_high = AdcW'(PresetHighRst12);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < $size(DirectedRows); i++) begin
      row = DirectedRows[i];
      send_tick(tick_of(int'(row.pot_right), int'(row.pot_left), row.btn, row.pins),
                row.typed, '{row.setpoint, row.drive});
    end
    s_axis_tvalid <= 1'b0;

    for (int phase = 0; phase < 6; phase++) begin
      wait_for_results();
      case (phase)
        0: begin
          gain = 255; mid_off = 0;    high_off = 4095; step = 255; lim = 127;
        end
        1: begin
          gain = 0;   mid_off = 4095; high_off = 0;    step = 0;   lim = 127;
        end
        2: begin
          gain = 255; mid_off = 4095; high_off = 0;    step = 1;   lim = 0;
        end
        default: begin
          gain     = $urandom_range(0, 255);
          mid_off  = $urandom_range(0, 4095);
          high_off = $urandom_range(0, 4095);
          step     = $urandom_range(0, 255);
          lim      = $urandom_range(0, 127);
        end
      endcase
      write_reg(REG_GAIN,        with_upper_noise(gain, GainW));
      write_reg(REG_MID_OFFSET,  with_upper_noise(mid_off, OffsetW));
      write_reg(REG_HIGH_OFFSET, with_upper_noise(high_off, OffsetW));
      write_reg(REG_NUDGE_STEP,  with_upper_noise(step, StepW));
      write_reg(REG_DRIVE_LIMIT, with_upper_noise(lim, LimitW));
      // A write past the register list must leave every register alone.
      write_reg(FirstUnusedIdx + RegIdxW'($urandom_range(0, 2)), $urandom());
      if (phase == 5) begin
        steady_run = 1'b1;
      end
      repeat (100) send_tick(random_tick(), 1'b0, '0);
      s_axis_tvalid <= 1'b0;
    end

    wait_for_results();
    if (pending_results.size() != 0) begin
      report_mismatch("results never delivered", 0, pending_results.size());
    end
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== arm_position_p_controller_unit.f =====
rtl/apc_pkg.sv
rtl/apc_cfg_regs.sv
rtl/apc_core.sv
rtl/arm_position_p_controller_unit.sv
bench/tb_arm_position_p_controller_unit.sv
